/* design/c32tc_pkg.sv */
package c32tc_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam int unsigned TrailerBytes = 4;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic [31:0] crc_computed;
    logic [31:0] crc_stored;
    logic        crc_match;
  } result_t;

  // One byte of reflected CRC-32, shifting out the low bit eight times.
  function automatic logic [31:0] crc32_byte_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/c32tc_if.sv */
interface c32tc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface c32tc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_computed;
  logic [31:0] crc_stored;
  logic        crc_match;

  modport source (output valid, output crc_computed, output crc_stored, output crc_match,
                  input ready);
  modport sink (input valid, input crc_computed, input crc_stored, input crc_match,
                output ready);
endinterface

/* design/crc32_trailer_check_top.sv */
// CRC-32 trailer check for an image streamed one byte per word.
// The input channel carries data_byte and last_byte; last_byte marks the final
// byte of the image. The last four bytes are the stored trailer, read as a
// little-endian word; all earlier bytes go through reflected CRC-32.
// The output channel carries one word per image: the computed CRC, the stored
// trailer and a match flag. Images of four bytes or fewer give a computed CRC
// of zero with the bytes in the low part of the trailer.
// Throughput is one byte per cycle unless a final byte waits on a held result:
// the window shift and one bitwise byte step of the CRC fit between the input
// register and the result register. The result of an image is captured from
// the final byte in the input register into the result register as it advances.
// When the receiver stalls with a result held, bytes of the next image keep
// flowing until the next final byte reaches the input register; that byte
// waits there and the input channel deasserts ready.
// Reset clears the valid flags of both registers and returns the CRC, window
// and fill count to their start values; no clearing pass is needed.
module crc32_trailer_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  c32tc_in_if.sink    in_i,
  c32tc_out_if.source out_o
);

  logic       in_valid_q;
  logic       in_last_q;
  logic [7:0] in_data_q;
  logic       advance;

  c32tc_pkg::step_t   step;
  c32tc_pkg::result_t result;
  c32tc_pkg::result_t out_q;
  logic               out_valid_q;

  assign advance    = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  assign step.valid = advance;
  assign step.last  = in_last_q;
  assign step.data  = in_data_q;

  c32tc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_last_q <= in_i.last_byte;
      in_data_q <= in_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_q <= result;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.crc_computed = out_q.crc_computed;
  assign out_o.crc_stored   = out_q.crc_stored;
  assign out_o.crc_match    = out_q.crc_match;

endmodule

/* design/c32tc_core.sv */
module c32tc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  c32tc_pkg::step_t   step_i,
  output c32tc_pkg::result_t result_o
);

  logic [31:0]     crc_q, crc_d, crc_upd;
  logic [3:0][7:0] win_q, win_d, win_upd;
  logic [2:0]      fill_q, fill_d, fill_upd;

  always_comb begin
    crc_upd  = crc_q;
    win_upd  = win_q;
    fill_upd = fill_q;
    if (fill_q[2]) begin
      // Window is full: the oldest byte leaves it and enters the CRC.
      crc_upd = c32tc_pkg::crc32_byte_step(crc_q, win_q[0]);
      win_upd = {step_i.data, win_q[3], win_q[2], win_q[1]};
    end else begin
      win_upd[fill_q[1:0]] = step_i.data;
      fill_upd = fill_q + 3'd1;
    end

    result_o.crc_computed = crc_upd ^ c32tc_pkg::CrcInit;
    result_o.crc_stored   = win_upd;
    result_o.crc_match    = (result_o.crc_computed == result_o.crc_stored);

    crc_d  = crc_q;
    win_d  = win_q;
    fill_d = fill_q;
    if (step_i.valid) begin
      if (step_i.last) begin
        crc_d  = c32tc_pkg::CrcInit;
        win_d  = '0;
        fill_d = '0;
      end else begin
        crc_d  = crc_upd;
        win_d  = win_upd;
        fill_d = fill_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= c32tc_pkg::CrcInit;
      win_q  <= '0;
      fill_q <= '0;
    end else begin
      crc_q  <= crc_d;
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

endmodule
